@@ design/ctsm_pkg.sv @@
// package for the camera timestamp mapper
// holds the item, state and result types and the fixed constants; no dependencies
`default_nettype none

package ctsm_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned PTS_W  = 63;
  // the stored offset host_origin - camera_origin needs one sign bit
  localparam int unsigned OFFSET_W = TIME_W + 1;

  localparam logic [PTS_W-1:0]  PTS_MAX              = {PTS_W{1'b1}};
  localparam logic [TIME_W-1:0] DEFAULT_MAX_ERROR_NS = 64'd2_000_000_000;

  // one input item
  typedef struct packed {
    logic [TIME_W-1:0] camera_time;
    logic [TIME_W-1:0] host_time;
    logic              reanchor_request;
  } item_t;

  // mapping state carried from item to item
  typedef struct packed {
    logic                anchored;
    logic [OFFSET_W-1:0] offset;
    logic [TIME_W-1:0]   previous_camera;
    logic [PTS_W-1:0]    previous_pts;
  } state_t;

  // one result item
  typedef struct packed {
    logic [PTS_W-1:0] pts;
    logic             discontinuity;
    logic             clock_fault;
    logic             from_camera;
  } result_t;

endpackage

`default_nettype wire

@@ design/ctsm_map.sv @@
// mapping logic of the camera timestamp mapper: one item and the current
// state in, result and next state out; depends on ctsm_pkg
`default_nettype none

module ctsm_map (
  input  var ctsm_pkg::item_t        item,
  input  var ctsm_pkg::state_t       state,
  input  var logic [63:0]            max_error_ns,
  output ctsm_pkg::result_t          result,
  output ctsm_pkg::state_t           state_next
);
  import ctsm_pkg::*;

  logic [PTS_W-1:0]    host_sat;
  logic                cam_zero;
  logic                fallback_low;
  logic [PTS_W-1:0]    fallback_pts;
  logic [OFFSET_W:0]   mapped;
  logic                map_overflow;
  logic [PTS_W-1:0]    mapped_sat;
  logic [OFFSET_W+1:0] diff;
  logic [OFFSET_W+1:0] err_hi;
  logic [OFFSET_W+1:0] err_lo;
  logic                too_far;
  logic                cam_not_up;
  logic                mapped_not_up;
  logic                misbehave;
  logic [OFFSET_W-1:0] anchor_offset;

  // saturated host time and zero camera time
  assign host_sat = item.host_time[TIME_W-1] ? PTS_MAX : item.host_time[PTS_W-1:0];
  assign cam_zero = (item.camera_time == '0);

  // fallback forced above the last result, saturating at PTS_MAX
  assign fallback_low = (host_sat <= state.previous_pts);
  assign fallback_pts = (state.previous_pts == PTS_MAX) ? PTS_MAX
                      : state.previous_pts + PTS_W'(1);

  // mapped = camera_time + (host_origin - camera_origin)
  assign mapped       = {2'b00, item.camera_time} + {state.offset[OFFSET_W-1], state.offset};
  assign map_overflow = (mapped[OFFSET_W:TIME_W] != '0);
  assign mapped_sat   = mapped[TIME_W-1] ? PTS_MAX : mapped[PTS_W-1:0];

  // signed distance to host time, checked against the error limit both ways
  assign diff = {3'b000, item.camera_time} + {{2{state.offset[OFFSET_W-1]}}, state.offset}
              - {3'b000, item.host_time};
  assign err_hi  = {3'b000, max_error_ns} - diff;
  assign err_lo  = {3'b000, max_error_ns} + diff;
  assign too_far = diff[OFFSET_W+1] ? err_lo[OFFSET_W+1] : err_hi[OFFSET_W+1];

  assign cam_not_up    = (state.previous_camera == '0)
                      || (item.camera_time <= state.previous_camera);
  assign mapped_not_up = (mapped_sat <= state.previous_pts);
  assign misbehave     = cam_not_up || map_overflow || mapped_not_up || too_far;

  assign anchor_offset = {1'b0, item.host_time} - {1'b0, item.camera_time};

  // select among anchor, fallback and mapped results
  always_comb begin
    result     = '0;
    state_next = state;
    priority if (item.reanchor_request || !state.anchored || (!cam_zero && misbehave)) begin
      result.pts                 = host_sat;
      result.discontinuity       = 1'b1;
      result.clock_fault         = state.anchored && !item.reanchor_request;
      result.from_camera         = !cam_zero;
      state_next.anchored        = 1'b1;
      state_next.offset          = anchor_offset;
      state_next.previous_camera = item.camera_time;
      state_next.previous_pts    = host_sat;
    end else if (cam_zero) begin
      result.pts                 = fallback_low ? fallback_pts : host_sat;
      result.discontinuity       = fallback_low;
      result.clock_fault         = fallback_low;
      result.from_camera         = 1'b0;
      state_next.previous_camera = '0;
      state_next.previous_pts    = fallback_low ? fallback_pts : host_sat;
    end else begin
      result.pts                 = mapped_sat;
      result.discontinuity       = 1'b0;
      result.clock_fault         = 1'b0;
      result.from_camera         = 1'b1;
      state_next.previous_camera = item.camera_time;
      state_next.previous_pts    = mapped_sat;
    end
  end

endmodule

`default_nettype wire

@@ design/camera_timestamp_mapper.sv @@
// camera timestamp mapper top level: input register, mapping logic, result register
// depends on ctsm_pkg and ctsm_map
//
// usage:
//   input channel in_valid/in_ready carries camera_time, host_time and
//   reanchor_request; output channel out_valid/out_ready carries pts,
//   discontinuity, clock_fault and from_camera, one result per item.
//   cfg_write/cfg_data set max_error_ns; write only while the block is idle.
// timing:
//   an item transferred into the input register is mapped by combinational
//   logic, and its result is registered in the output register once that
//   register is free. one item per cycle is sustained while out_ready stays
//   high; the mapping state updates as each result is registered, so the
//   next item is mapped with the updated state.
// reset:
//   rst (synchronous) empties both registers, clears the anchor so the next
//   item re-anchors, and sets max_error_ns to 2000000000.
// stall:
//   while out_ready is low the result holds; the input register still takes
//   one more item, then in_ready drops until the output drains.
`default_nettype none

module camera_timestamp_mapper (
  input  var logic        clk,
  input  var logic        rst,
  input  var logic        in_valid,
  output logic            in_ready,
  input  var logic [63:0] camera_time,
  input  var logic [63:0] host_time,
  input  var logic        reanchor_request,
  output logic            out_valid,
  input  var logic        out_ready,
  output logic [62:0]     pts,
  output logic            discontinuity,
  output logic            clock_fault,
  output logic            from_camera,
  input  var logic        cfg_write,
  input  var logic [63:0] cfg_data
);
  import ctsm_pkg::*;

  logic        s1_valid;
  item_t       s1_item;
  state_t      state;
  state_t      state_next;
  result_t     result;
  result_t     out_result;
  logic [63:0] max_error_ns;
  logic        advance;

  // move the input register into the output register when it is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  ctsm_map u_map (
    .item         (s1_item),
    .state        (state),
    .max_error_ns (max_error_ns),
    .result       (result),
    .state_next   (state_next)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_error_ns <= DEFAULT_MAX_ERROR_NS;
    end else if (cfg_write) begin
      max_error_ns <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.camera_time      <= camera_time;
      s1_item.host_time        <= host_time;
      s1_item.reanchor_request <= reanchor_request;
    end
  end

  // mapping state, updated on each registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign pts           = out_result.pts;
  assign discontinuity = out_result.discontinuity;
  assign clock_fault   = out_result.clock_fault;
  assign from_camera   = out_result.from_camera;

endmodule

`default_nettype wire
